@@ sv/fpadd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpadd_pkg: shared constants and types for the single-precision adder
// Field masks, special codes and the stage records passed between modules.
// ----------------------------------------------------------------------------
package fpadd_pkg;

	localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
	localparam logic [7:0]  EXP_MAX    = 8'hFF;
	localparam int          PIPE_DEPTH = 4;

	// Aligned operands, ready for the add or subtract.
	typedef struct packed {
		logic        special;
		logic [31:0] special_bits;
		logic        sa;
		logic        sb;
		logic [7:0]  e;
		logic [23:0] ma;
		logic [23:0] mb;
	} align_t;

	// Raw magnitude sum before normalization.
	typedef struct packed {
		logic        special;
		logic [31:0] special_bits;
		logic        s;
		logic [7:0]  e;
		logic [24:0] m;
	} sum_t;

	// Leading-zero count found, shift applied in the last stage.
	typedef struct packed {
		logic        special;
		logic [31:0] special_bits;
		logic        s;
		logic [8:0]  e;
		logic [23:0] m;
		logic [4:0]  lz;
	} norm_t;

endpackage

@@ sv/float32_adder_truncating_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_adder_truncating_top: pipelined single-precision adder
// Truncating alignment and truncating normalization; exponent overflow gives infinity.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// in      | to block  | in_valid/in_stall  | operand_a, operand_b
// out     | from block| out_valid/out_stall| sum_bits
//
// Four register stages: align, add, leading-zero count, shift and pack.
// One item can enter every cycle while in_stall is low. Its result passes through
// al_s1, sm_s2, nm_s3 and res_s4 in turn and is then shown on sum_bits.
// Reset clears only the stage valid bits.
// A stall on the output holds the last stage; earlier items close up into
// empty stages, and in_stall rises only when all four stages are full.
// ----------------------------------------------------------------------------
module float32_adder_truncating_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] sum_bits
);

	fpadd_pkg::align_t al, al_s1;
	fpadd_pkg::sum_t   sm, sm_s2;
	fpadd_pkg::norm_t  nm, nm_s3;
	logic [31:0]       res, res_s4;
	logic [3:0]        v_q;
	logic              adv;

	// Free slots let items move up even while the output is stalled.
	logic [3:0] mv;
	always_comb begin
		mv[3] = !v_q[3] || !out_stall;
		mv[2] = !v_q[2] || mv[3];
		mv[1] = !v_q[1] || mv[2];
		mv[0] = !v_q[0] || mv[1];
	end
	assign adv      = mv[0];
	assign in_stall = !adv;

	fpadd_align u_align (.a(operand_a), .b(operand_b), .al(al));

	always_comb begin
		sm.special      = al_s1.special;
		sm.special_bits = al_s1.special_bits;
		sm.e            = al_s1.e;
		if (al_s1.sa == al_s1.sb) begin
			sm.m = {1'b0, al_s1.ma} + {1'b0, al_s1.mb};
			sm.s = al_s1.sa;
		end else if (al_s1.ma > al_s1.mb) begin
			sm.m = {1'b0, al_s1.ma - al_s1.mb};
			sm.s = al_s1.sa;
		end else begin
			sm.m = {1'b0, al_s1.mb - al_s1.ma};
			sm.s = al_s1.sb;
		end
	end

	fpadd_norm u_norm (.sm(sm_s2), .nm(nm));

	logic [23:0] mf;
	logic [8:0]  ef;
	always_comb begin
		mf = nm_s3.m << nm_s3.lz;
		ef = nm_s3.e - {4'd0, nm_s3.lz};
		if (nm_s3.special) begin
			res = nm_s3.special_bits;
		end else if (!mf[23]) begin
			res = {nm_s3.s, 8'd0, mf[22:0]};
		end else if (ef >= {1'b0, fpadd_pkg::EXP_MAX}) begin
			res = {nm_s3.s, fpadd_pkg::EXP_MAX, 23'd0};
		end else begin
			res = {nm_s3.s, ef[7:0], mf[22:0]};
		end
		if (res == 32'h8000_0000) res = 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 4'd0;
		end else begin
			if (mv[0]) v_q[0] <= in_valid;
			if (mv[1]) v_q[1] <= v_q[0];
			if (mv[2]) v_q[2] <= v_q[1];
			if (mv[3]) v_q[3] <= v_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (mv[0]) al_s1  <= al;
		if (mv[1]) sm_s2  <= sm;
		if (mv[2]) nm_s3  <= nm;
		if (mv[3]) res_s4 <= res;
	end

	assign out_valid = v_q[3];
	assign sum_bits  = res_s4;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sum_bits))
		else $error("result changed under stall");
	a_noneg0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sum_bits != 32'h8000_0000)
		else $error("negative zero produced");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[2] && !v_q[3] |=> v_q[3])
		else $error("item lost before output stage");
	a_stallfull: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_q == 4'hF)
		else $error("input stalled with a free slot");

endmodule

@@ sv/fpadd_align.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpadd_align: operand unpack, special cases and exponent alignment
// Combinational front end feeding the first pipeline register.
// ----------------------------------------------------------------------------
module fpadd_align (
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	output fpadd_pkg::align_t al
);

	logic [7:0]  ea, eb, ea_eff, eb_eff, d;
	logic [22:0] fa, fb;
	logic [23:0] ma, mb;
	logic        nan_a, nan_b, inf_a, inf_b, a_big;

	always_comb begin
		ea = a[30:23];
		eb = b[30:23];
		fa = a[22:0];
		fb = b[22:0];
		nan_a = (ea == fpadd_pkg::EXP_MAX) && (fa != 23'd0);
		nan_b = (eb == fpadd_pkg::EXP_MAX) && (fb != 23'd0);
		inf_a = (ea == fpadd_pkg::EXP_MAX);
		inf_b = (eb == fpadd_pkg::EXP_MAX);
		ma = {(ea != 8'd0), fa};
		mb = {(eb != 8'd0), fb};
		ea_eff = (ea == 8'd0) ? 8'd1 : ea;
		eb_eff = (eb == 8'd0) ? 8'd1 : eb;
		a_big = ea_eff > eb_eff;
		d = a_big ? (ea_eff - eb_eff) : (eb_eff - ea_eff);

		al.special = inf_a || inf_b;
		if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) begin
			al.special_bits = fpadd_pkg::CANON_NAN;
		end else if (inf_a) begin
			al.special_bits = a;
		end else begin
			al.special_bits = b;
		end
		al.sa = a[31];
		al.sb = b[31];
		al.e  = a_big ? ea_eff : eb_eff;
		// Shifts of 24 or more are forced to zero, since only d[4:0] drives the shifter.
		al.ma = (!a_big && d >= 8'd24) ? 24'd0 : (a_big ? ma : (ma >> d[4:0]));
		al.mb = (a_big && d >= 8'd24) ? 24'd0 : (a_big ? (mb >> d[4:0]) : mb);
	end

endmodule

@@ sv/fpadd_norm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpadd_norm: carry handling and leading-zero count
// Turns the raw sum into a 24-bit significand and a left-shift amount.
// ----------------------------------------------------------------------------
module fpadd_norm (
	input  fpadd_pkg::sum_t  sm,
	output fpadd_pkg::norm_t nm
);

	logic [23:0] m;
	logic [8:0]  e;
	logic [4:0]  lz;
	logic [4:0]  lim;

	always_comb begin
		if (sm.m[24]) begin
			m = sm.m[24:1];
			e = {1'b0, sm.e} + 9'd1;
		end else begin
			m = sm.m[23:0];
			e = {1'b0, sm.e};
		end
		lz = 5'd24;
		for (int i = 0; i < 24; i++) begin
			if (m[i]) lz = 5'(23 - i);
		end
		// Never shift the exponent below one; the value then stays subnormal.
		lim = (e - 9'd1 < 9'd24) ? 5'(e - 9'd1) : 5'd24;
		nm.special      = sm.special;
		nm.special_bits = sm.special_bits;
		nm.s  = sm.s;
		nm.e  = e;
		nm.m  = m;
		nm.lz = (lz < lim) ? lz : lim;
	end

endmodule
